### sv/sqi_pkg.sv
// sqi_pkg: shared types and codes for the shift queue with positional insert
// no dependencies; used by the interfaces, the cell and the top level

package sqi_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  // command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,        // keep the word
    CELL_SHIFT_HEAD,  // take the word of the neighbor toward the tail
    CELL_OPEN         // load at target, take neighbor toward head past target
  } cell_mode_t;

endpackage

### sv/sqi_in_if.sv
// sqi_in_if: request channel of the shift queue (action, position, value)
// depends on sqi_pkg

interface sqi_in_if;
  logic                            valid;
  logic                            ready;
  logic [sqi_pkg::ACTION_W-1:0]    action;
  logic [sqi_pkg::POS_W-1:0]       position;
  logic signed [sqi_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output position, output value,
                  input ready);
  modport sink   (input valid, input action, input position, input value,
                  output ready);
endinterface

### sv/sqi_out_if.sv
// sqi_out_if: result channel of the shift queue (status, removed value, fill)
// depends on sqi_pkg

interface sqi_out_if;
  logic                              valid;
  logic                              ready;
  logic [sqi_pkg::STATUS_W-1:0]      status;
  logic signed [sqi_pkg::DATA_W-1:0] removed_value;
  logic [sqi_pkg::FILL_W-1:0]        fill_count;

  modport source (output valid, output status, output removed_value,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input fill_count, output ready);
endinterface

### sv/sqi_cell.sv
// sqi_cell: one storage slot of the shift queue chain
// depends on sqi_pkg; compares its own slot number against the broadcast target

module sqi_cell #(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  sqi_pkg::cell_mode_t    mode,
  input  logic [IW-1:0]          tgt,
  input  sqi_pkg::data_t         load_data,
  input  sqi_pkg::data_t         prev_data,  // neighbor toward head
  input  sqi_pkg::data_t         next_data,  // neighbor toward tail
  output sqi_pkg::data_t         data
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  sqi_pkg::data_t data_r;
  sqi_pkg::data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (mode)
      sqi_pkg::CELL_HOLD:       data_nxt = data_r;
      sqi_pkg::CELL_SHIFT_HEAD: data_nxt = next_data;
      sqi_pkg::CELL_OPEN: begin
        if (MY_IDX == tgt) begin
          data_nxt = load_data;
        end else if (MY_IDX > tgt) begin
          data_nxt = prev_data;
        end
      end
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### sv/shift_queue_with_positional_insert.sv
// shift_queue_with_positional_insert: packed queue with push, remove and insert
// depends on sqi_pkg, sqi_in_if, sqi_out_if and sqi_cell
//
//   channel | dir | payload                               | handshake
//   in_ch   | in  | action, position, value               | valid/ready
//   out_ch  | out | status, removed_value, fill_count     | valid/ready
//
// one transaction per clock: the cells shift or load in the same edge that
// takes the request, so throughput is one item per cycle while out_ch takes
// results, and the result shows in the cycle after acceptance, held in the
// output register. in_ch.ready is high while the output register is empty or
// being drained. synchronous active-low reset clears the occupancy count and
// the output valid; the stored words are left as they are.

module shift_queue_with_positional_insert #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sqi_in_if.sink     in_ch,
  sqi_out_if.source  out_ch
);

  // occupancy counts 0..DEPTH
  localparam int OW = $clog2(DEPTH + 1);
  // width to compare position with occupancy and to take the fill field
  localparam int CW = (OW > sqi_pkg::POS_W) ? OW : sqi_pkg::POS_W;
  localparam logic [OW-1:0] DEPTH_OCC = OW'(DEPTH);

  logic [OW-1:0] occ_r;
  logic [OW-1:0] occ_nxt;

  logic                             out_valid_r;
  logic [sqi_pkg::STATUS_W-1:0]     status_r;
  logic [sqi_pkg::STATUS_W-1:0]     status_nxt;
  sqi_pkg::data_t                   removed_r;
  sqi_pkg::data_t                   removed_nxt;
  logic [sqi_pkg::FILL_W-1:0]       fill_r;
  logic [sqi_pkg::FILL_W-1:0]       fill_nxt;

  logic                  accept;
  logic                  full;
  logic [CW-1:0]         pos_ext;
  logic [CW-1:0]         occ_ext;
  logic [CW-1:0]         occ_nxt_ext;
  sqi_pkg::cell_mode_t   mode;
  logic [OW-1:0]         tgt;

  sqi_pkg::data_t cell_data [DEPTH];

  // output register frees up when the current result is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full    = (occ_r == DEPTH_OCC);
  assign pos_ext = CW'(in_ch.position);
  assign occ_ext = CW'(occ_r);

  // decode the request into a broadcast cell command and the new count
  always_comb begin
    mode        = sqi_pkg::CELL_HOLD;
    tgt         = occ_r;
    occ_nxt     = occ_r;
    status_nxt  = sqi_pkg::ST_OK;
    removed_nxt = '0;
    case (in_ch.action)
      sqi_pkg::ACT_PUSH: begin
        if (full) begin
          status_nxt = sqi_pkg::ST_FULL;
        end else begin
          // append: target is the first free slot
          mode    = sqi_pkg::CELL_OPEN;
          tgt     = occ_r;
          occ_nxt = occ_r + OW'(1);
        end
      end
      sqi_pkg::ACT_REMOVE: begin
        if (occ_r == '0) begin
          status_nxt = sqi_pkg::ST_EMPTY;
        end else begin
          mode        = sqi_pkg::CELL_SHIFT_HEAD;
          removed_nxt = cell_data[0];
          occ_nxt     = occ_r - OW'(1);
        end
      end
      sqi_pkg::ACT_INSERT: begin
        // full check wins over the position check
        if (full) begin
          status_nxt = sqi_pkg::ST_FULL;
        end else if (pos_ext > occ_ext) begin
          status_nxt = sqi_pkg::ST_BADPOS;
        end else begin
          // position is at most occupancy here, so it fits the slot index
          mode    = sqi_pkg::CELL_OPEN;
          tgt     = OW'(in_ch.position);
          occ_nxt = occ_r + OW'(1);
        end
      end
      default: begin
        // unused action leaves the cells and the count as they are and reports ok
        status_nxt = sqi_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      mode = sqi_pkg::CELL_HOLD;
    end
  end

  assign occ_nxt_ext = CW'(occ_nxt);
  assign fill_nxt    = occ_nxt_ext[sqi_pkg::FILL_W-1:0];

  // chain of cells, head at slot 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sqi_pkg::data_t prev_d;
    sqi_pkg::data_t next_d;
    if (i == 0) begin : g_head
      assign prev_d = in_ch.value;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end
    sqi_cell #(
      .IW  (OW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .tgt       (tgt),
      .load_data (in_ch.value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i])
    );
  end

  // fill count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      fill_r    <= fill_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.fill_count    = fill_r;

  // never holds more than the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_OCC)
    else $error("occupancy above depth");

  // a successful remove takes exactly one word
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == sqi_pkg::ACT_REMOVE && occ_r != '0)
      |=> (occ_r == $past(occ_r) - OW'(1)))
    else $error("remove did not drop the count by one");

  // an empty report carries no word and a zero count
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == sqi_pkg::ST_EMPTY)
      |-> (removed_r == '0 && fill_r == '0))
    else $error("empty status with data or nonzero fill");

  // every accepted transaction leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule
